FILE: src/fbtb_pkg.sv
// ============================================================================
// fbtb_pkg - shared types and constants of the framebuffer text blitter
// Word formats, command codes, the 5x7 glyph ROM and frame geometry helpers.
// ============================================================================
package fbtb_pkg;

    localparam int DEF_PANEL_WIDTH  = 200;
    localparam int DEF_PANEL_HEIGHT = 200;
    localparam int DEF_MAX_TEXT_LEN = 64;

    localparam int GLYPH_COUNT = 10;
    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COLS  = 5;
    localparam int CELL_UNITS  = GLYPH_COLS + 1;
    localparam int GLYPH_IDX_W = 4;

    localparam logic [7:0] FILL_WHITE = 8'hFF;
    localparam logic [7:0] LEFT_PIXEL = 8'h80;

    typedef enum logic [2:0] {
        CMD_CLEAR      = 3'd0,
        CMD_PIXEL      = 3'd1,
        CMD_TEXT_BEGIN = 3'd2,
        CMD_TEXT_CHAR  = 3'd3,
        CMD_READ       = 3'd4
    } cmd_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] pixel_x;
        logic [15:0] pixel_y;
        logic        ink_color;
        logic [3:0]  text_scale;
        logic [6:0]  text_length;
        logic [7:0]  char_code;
        logic [12:0] byte_index;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  read_byte;
        logic [15:0] text_cursor;
    } out_word_t;

    // Sequencer to pixel walker
    typedef struct packed {
        logic load_pixel;
        logic load_glyph;
        logic advance;
    } walk_ctrl_t;

    // Pixel walker to sequencer
    typedef struct packed {
        logic       bit_on;
        logic       in_panel;
        logic       last;
        logic [7:0] mask;
    } walk_stat_t;

    typedef struct packed {
        logic                   hit;
        logic [GLYPH_IDX_W-1:0] idx;
    } glyph_hit_t;

    function automatic int frame_bytes(input int w, input int h);
        return ((w + 7) >> 3) * h;
    endfunction

    function automatic int frame_addr_w(input int w, input int h);
        return (frame_bytes(w, h) > 1) ? $clog2(frame_bytes(w, h)) : 1;
    endfunction

    function automatic logic [7:0] glyph_code(input logic [GLYPH_IDX_W-1:0] g);
        logic [7:0] code;
        unique case (g)
            4'd0:    code = 8'h53; // S
            4'd1:    code = 8'h4C; // L
            4'd2:    code = 8'h74; // t
            4'd3:    code = 8'h6F; // o
            4'd4:    code = 8'h70; // p
            4'd5:    code = 8'h69; // i
            4'd6:    code = 8'h73; // s
            4'd7:    code = 8'h65; // e
            4'd8:    code = 8'h6E; // n
            4'd9:    code = 8'h67; // g
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    function automatic glyph_hit_t glyph_find(input logic [7:0] code);
        glyph_hit_t res;
        res.hit = 1'b0;
        res.idx = '0;
        for (int i = GLYPH_COUNT - 1; i >= 0; i--)
        begin
            if (glyph_code(GLYPH_IDX_W'(i)) == code)
            begin
                res.hit = 1'b1;
                res.idx = GLYPH_IDX_W'(i);
            end
        end
        return res;
    endfunction

    // Row r of glyph g, leftmost pixel in bit 4
    function automatic logic [GLYPH_COLS-1:0] glyph_row(input logic [GLYPH_IDX_W-1:0] g,
                                                        input logic [2:0] r);
        logic [GLYPH_ROWS*GLYPH_COLS-1:0] rows;
        unique case (g)
            4'd0: rows = {5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E};
            4'd1: rows = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            4'd2: rows = {5'h08, 5'h08, 5'h1E, 5'h08, 5'h08, 5'h09, 5'h06};
            4'd3: rows = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h11, 5'h11, 5'h0E};
            4'd4: rows = {5'h00, 5'h00, 5'h1E, 5'h11, 5'h1E, 5'h10, 5'h10};
            4'd5: rows = {5'h08, 5'h00, 5'h18, 5'h08, 5'h08, 5'h08, 5'h1C};
            4'd6: rows = {5'h00, 5'h00, 5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E};
            4'd7: rows = {5'h00, 5'h00, 5'h0E, 5'h11, 5'h1F, 5'h10, 5'h0E};
            4'd8: rows = {5'h00, 5'h00, 5'h16, 5'h19, 5'h11, 5'h11, 5'h11};
            4'd9: rows = {5'h00, 5'h00, 5'h0F, 5'h11, 5'h0F, 5'h01, 5'h1E};
            default: rows = '0;
        endcase
        return GLYPH_COLS'(rows >> (GLYPH_COLS * (GLYPH_ROWS - 1 - int'(r))));
    endfunction

endpackage

FILE: src/mono_framebuffer_text_blitter_core.sv
// ============================================================================
// mono_framebuffer_text_blitter_core - 1 bpp framebuffer with 5x7 text
// Sequencer, frame RAM and pixel walker of the framebuffer engine.
// ============================================================================
// One input word carries one command; each command returns one output word
// holding the read byte (zero unless the command is a read) and the text
// cursor x after the command. The block takes one command at a time:
// in_ready is high only while the sequencer idles, but a finished word may
// wait in the output register while the next command is taken. All frame
// traffic goes to a single frame RAM (one write and one registered read
// port): clear fills every byte with FILL_WHITE, and a pixel draw is a
// read-modify-write of its byte, skipped for a pixel off the panel.
// Each lit on-panel glyph pixel is read, then written back; a blank glyph
// cell is stepped over whole in each of its pixel rows. Frame bytes are not
// initialized at reset: a read before any clear or draw returns garbage.
// A text string is centred from its length and scale at text begin (at 0
// on an axis that it fills); each known character is painted in
// scale-by-scale squares clipped at the panel edge and the cursor then
// moves right by 6 * scale, wrapping at 16 bits.
// ============================================================================
module mono_framebuffer_text_blitter_core #(
    parameter int PANEL_WIDTH  = fbtb_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = fbtb_pkg::DEF_PANEL_HEIGHT,
    parameter int MAX_TEXT_LEN = fbtb_pkg::DEF_MAX_TEXT_LEN
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fbtb_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fbtb_pkg::out_word_t out_data
);
    import fbtb_pkg::*;

    localparam int FRAME_BYTES = frame_bytes(PANEL_WIDTH, PANEL_HEIGHT);
    localparam int ADDR_W      = frame_addr_w(PANEL_WIDTH, PANEL_HEIGHT);
    localparam int LEN_W       = $clog2(MAX_TEXT_LEN + 1);
    localparam int TW_W        = LEN_W + 7;
    localparam int CW          = (TW_W > 11) ? TW_W : 11;
    localparam int RD_W        = (ADDR_W > 13) ? ADDR_W : 13;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_CLEAR   = 8'b0000_0010,
        S_PIXEL   = 8'b0000_0100,
        S_WRITE   = 8'b0000_1000,
        S_RCAP    = 8'b0001_0000,
        S_TBEGIN  = 8'b0010_0000,
        S_ADVANCE = 8'b0100_0000,
        S_FINISH  = 8'b1000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [15:0]     cursor_x_reg, cursor_x_next;
    logic [15:0]     cursor_y_reg, cursor_y_next;
    logic [3:0]      active_scale_reg, active_scale_next;
    logic            active_color_reg, active_color_next;
    logic            text_enabled_reg, text_enabled_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [7:0]      mask_reg, mask_next;
    logic            paint_color_reg, paint_color_next;
    logic            text_op_reg, text_op_next;
    logic            rd_ok_reg, rd_ok_next;
    logic [7:0]      rd_byte_reg, rd_byte_next;
    out_word_t       out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    walk_ctrl_t      walk_ctrl;
    walk_stat_t      walk_stat;
    logic [ADDR_W-1:0] walk_addr;

    logic            ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]      ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]      ram_rdata;

    glyph_hit_t      glyph;
    logic [7:0]      len_ext;
    logic [7:0]      len_sat;
    logic [LEN_W+3:0] len_scale;
    logic [TW_W-1:0] text_w;
    logic [6:0]      text_h;
    logic [6:0]      cell_step;
    state_t          paint_done;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        glyph     = glyph_find(in_data.char_code);
        len_ext   = {1'b0, in_data.text_length};
        len_sat   = (len_ext > 8'(MAX_TEXT_LEN)) ? 8'(MAX_TEXT_LEN) : len_ext;
        len_scale = (LEN_W + 4)'(len_reg) * (LEN_W + 4)'(active_scale_reg);
        // width = len * 6 * scale - scale, height = 7 * scale
        text_w    = (TW_W'(len_scale) << 2) + (TW_W'(len_scale) << 1)
                    - TW_W'(active_scale_reg);
        text_h    = (7'(active_scale_reg) << 3) - 7'(active_scale_reg);
        cell_step = (7'(active_scale_reg) << 2) + (7'(active_scale_reg) << 1);
        paint_done = text_op_reg ? S_ADVANCE : S_FINISH;
    end

    // RAM ports: read byte index while idle, walker address otherwise
    always_comb
    begin
        ram_raddr = (state_reg == S_IDLE) ? ADDR_W'(in_data.byte_index) : walk_addr;
        ram_we    = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
        ram_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : addr_reg;
        if (state_reg == S_CLEAR)
        begin
            ram_wdata = FILL_WHITE;
        end
        else if (paint_color_reg)
        begin
            ram_wdata = ram_rdata | mask_reg;
        end
        else
        begin
            ram_wdata = ram_rdata & ~mask_reg;
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        cursor_x_next     = cursor_x_reg;
        cursor_y_next     = cursor_y_reg;
        active_scale_next = active_scale_reg;
        active_color_next = active_color_reg;
        text_enabled_next = text_enabled_reg;
        len_next          = len_reg;
        clr_cnt_next      = clr_cnt_reg;
        addr_next         = addr_reg;
        mask_next         = mask_reg;
        paint_color_next  = paint_color_reg;
        text_op_next      = text_op_reg;
        rd_ok_next        = rd_ok_reg;
        rd_byte_next      = rd_byte_reg;
        out_next          = out_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        walk_ctrl         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rd_byte_next = '0;
                    unique case (in_data.command)
                        CMD_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            state_next   = S_CLEAR;
                        end
                        CMD_PIXEL:
                        begin
                            walk_ctrl.load_pixel = 1'b1;
                            paint_color_next     = in_data.ink_color;
                            text_op_next         = 1'b0;
                            state_next           = S_PIXEL;
                        end
                        CMD_TEXT_BEGIN:
                        begin
                            active_scale_next = in_data.text_scale;
                            active_color_next = in_data.ink_color;
                            len_next          = LEN_W'(len_sat);
                            state_next        = S_TBEGIN;
                        end
                        CMD_TEXT_CHAR:
                        begin
                            if (text_enabled_reg && (active_scale_reg != 4'd0))
                            begin
                                if (glyph.hit)
                                begin
                                    walk_ctrl.load_glyph = 1'b1;
                                    paint_color_next     = active_color_reg;
                                    text_op_next         = 1'b1;
                                    state_next           = S_PIXEL;
                                end
                                else
                                begin
                                    state_next = S_ADVANCE;
                                end
                            end
                            else
                            begin
                                state_next = S_FINISH;
                            end
                        end
                        CMD_READ:
                        begin
                            rd_ok_next = RD_W'(in_data.byte_index) < RD_W'(FRAME_BYTES);
                            state_next = S_RCAP;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(FRAME_BYTES - 1))
                begin
                    state_next = S_FINISH;
                end
            end

            S_PIXEL:
            begin
                // RAM reads the walker address this cycle
                addr_next = walk_addr;
                mask_next = walk_stat.mask;
                if (walk_stat.bit_on && walk_stat.in_panel)
                begin
                    state_next = S_WRITE;
                end
                else if (walk_stat.last)
                begin
                    state_next = paint_done;
                end
                else
                begin
                    walk_ctrl.advance = 1'b1;
                end
            end

            S_WRITE:
            begin
                if (walk_stat.last)
                begin
                    state_next = paint_done;
                end
                else
                begin
                    walk_ctrl.advance = 1'b1;
                    state_next        = S_PIXEL;
                end
            end

            S_RCAP:
            begin
                rd_byte_next = rd_ok_reg ? ram_rdata : 8'd0;
                state_next   = S_FINISH;
            end

            S_TBEGIN:
            begin
                if ((len_reg == '0) || (active_scale_reg == 4'd0))
                begin
                    text_enabled_next = 1'b0;
                    cursor_x_next     = '0;
                    cursor_y_next     = '0;
                end
                else
                begin
                    text_enabled_next = 1'b1;
                    // centre, or start at 0 when the text fills the axis
                    if (CW'(text_w) < CW'(PANEL_WIDTH))
                    begin
                        cursor_x_next = 16'((CW'(PANEL_WIDTH) - CW'(text_w)) >> 1);
                    end
                    else
                    begin
                        cursor_x_next = '0;
                    end
                    if (11'(text_h) < 11'(PANEL_HEIGHT))
                    begin
                        cursor_y_next = 16'((11'(PANEL_HEIGHT) - 11'(text_h)) >> 1);
                    end
                    else
                    begin
                        cursor_y_next = '0;
                    end
                end
                state_next = S_FINISH;
            end

            S_ADVANCE:
            begin
                cursor_x_next = cursor_x_reg + 16'(cell_step);
                state_next    = S_FINISH;
            end

            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_next.read_byte   = rd_byte_reg;
                    out_next.text_cursor = cursor_x_reg;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cursor_x_reg     <= '0;
            cursor_y_reg     <= '0;
            active_scale_reg <= '0;
            active_color_reg <= 1'b0;
            text_enabled_reg <= 1'b0;
            clr_cnt_reg      <= '0;
            text_op_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cursor_x_reg     <= cursor_x_next;
            cursor_y_reg     <= cursor_y_next;
            active_scale_reg <= active_scale_next;
            active_color_reg <= active_color_next;
            text_enabled_reg <= text_enabled_next;
            clr_cnt_reg      <= clr_cnt_next;
            text_op_reg      <= text_op_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg         <= len_next;
        addr_reg        <= addr_next;
        mask_reg        <= mask_next;
        paint_color_reg <= paint_color_next;
        rd_ok_reg       <= rd_ok_next;
        rd_byte_reg     <= rd_byte_next;
        out_reg         <= out_next;
    end

    fbtb_walker #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (walk_ctrl),
        .pixel_x   (in_data.pixel_x),
        .pixel_y   (in_data.pixel_y),
        .org_x     (cursor_x_reg),
        .org_y     (cursor_y_reg),
        .scale     (active_scale_reg),
        .glyph_idx (glyph.idx),
        .stat      (walk_stat),
        .addr      (walk_addr)
    );

    fbtb_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

FILE: src/fbtb_ram.sv
// ============================================================================
// fbtb_ram - generic single-write, single-read RAM
// One write port and one read port; read data registered.
// ============================================================================
module fbtb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 5000
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: src/fbtb_walker.sv
// ============================================================================
// fbtb_walker - pixel coordinate walker
// Steps over the pixels of one scaled glyph (or holds one single pixel),
// skips blank glyph cells whole, and forms byte address, mask and clip flag.
// ============================================================================
module fbtb_walker #(
    parameter int PANEL_WIDTH  = fbtb_pkg::DEF_PANEL_WIDTH,
    parameter int PANEL_HEIGHT = fbtb_pkg::DEF_PANEL_HEIGHT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fbtb_pkg::walk_ctrl_t           ctrl,
    input  logic [15:0]                    pixel_x,
    input  logic [15:0]                    pixel_y,
    input  logic [15:0]                    org_x,
    input  logic [15:0]                    org_y,
    input  logic [3:0]                     scale,
    input  logic [fbtb_pkg::GLYPH_IDX_W-1:0] glyph_idx,
    output fbtb_pkg::walk_stat_t           stat,
    output logic [fbtb_pkg::frame_addr_w(PANEL_WIDTH, PANEL_HEIGHT)-1:0] addr
);
    import fbtb_pkg::*;

    localparam int ROW_BYTES = (PANEL_WIDTH + 7) / 8;
    localparam int ADDR_W    = frame_addr_w(PANEL_WIDTH, PANEL_HEIGHT);

    logic                   glyph_mode_reg, glyph_mode_next;
    logic [15:0]            x_reg, x_next;
    logic [15:0]            y_reg, y_next;
    logic [15:0]            org_x_reg, org_x_next;
    logic [3:0]             scale_reg, scale_next;
    logic [GLYPH_IDX_W-1:0] gidx_reg, gidx_next;
    logic [2:0]             r_reg, r_next;
    logic [2:0]             c_reg, c_next;
    logic [3:0]             dx_reg, dx_next;
    logic [3:0]             dy_reg, dy_next;

    logic [GLYPH_COLS-1:0]  row_bits;
    logic [2:0]             col_sel;
    logic                   bit_on;
    logic                   cell_end;
    logic                   line_end;
    logic                   band_end;

    always_comb
    begin
        row_bits = glyph_row(gidx_reg, r_reg);
        col_sel  = 3'(GLYPH_COLS - 1) - c_reg;
        bit_on   = glyph_mode_reg ? row_bits[col_sel] : 1'b1;
        // a blank cell ends at once, a lit one after scale pixels
        cell_end = !bit_on || (dx_reg == scale_reg - 4'd1);
        line_end = cell_end && (c_reg == 3'(GLYPH_COLS - 1));
        band_end = line_end && (dy_reg == scale_reg - 4'd1);

        stat.bit_on   = bit_on;
        stat.in_panel = (x_reg < 16'(PANEL_WIDTH)) && (y_reg < 16'(PANEL_HEIGHT));
        stat.last     = !glyph_mode_reg || (band_end && (r_reg == 3'(GLYPH_ROWS - 1)));
        stat.mask     = LEFT_PIXEL >> x_reg[2:0];

        addr = ADDR_W'(ADDR_W'(y_reg) * ADDR_W'(ROW_BYTES)) + ADDR_W'(x_reg[15:3]);
    end

    always_comb
    begin
        glyph_mode_next = glyph_mode_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        org_x_next      = org_x_reg;
        scale_next      = scale_reg;
        gidx_next       = gidx_reg;
        r_next          = r_reg;
        c_next          = c_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;

        priority if (ctrl.load_pixel)
        begin
            glyph_mode_next = 1'b0;
            x_next          = pixel_x;
            y_next          = pixel_y;
        end
        else if (ctrl.load_glyph)
        begin
            glyph_mode_next = 1'b1;
            x_next          = org_x;
            y_next          = org_y;
            org_x_next      = org_x;
            scale_next      = scale;
            gidx_next       = glyph_idx;
            r_next          = '0;
            c_next          = '0;
            dx_next         = '0;
            dy_next         = '0;
        end
        else if (ctrl.advance)
        begin
            if (!cell_end)
            begin
                dx_next = dx_reg + 4'd1;
                x_next  = x_reg + 16'd1;
            end
            else if (!line_end)
            begin
                dx_next = '0;
                c_next  = c_reg + 3'd1;
                x_next  = bit_on ? x_reg + 16'd1 : x_reg + 16'(scale_reg);
            end
            else
            begin
                dx_next = '0;
                c_next  = '0;
                x_next  = org_x_reg;
                y_next  = y_reg + 16'd1;
                if (!band_end)
                begin
                    dy_next = dy_reg + 4'd1;
                end
                else
                begin
                    dy_next = '0;
                    r_next  = r_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glyph_mode_reg <= 1'b0;
            r_reg          <= '0;
            c_reg          <= '0;
            dx_reg         <= '0;
            dy_reg         <= '0;
            scale_reg      <= '0;
            gidx_reg       <= '0;
        end
        else
        begin
            glyph_mode_reg <= glyph_mode_next;
            r_reg          <= r_next;
            c_reg          <= c_next;
            dx_reg         <= dx_next;
            dy_reg         <= dy_next;
            scale_reg      <= scale_next;
            gidx_reg       <= gidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        org_x_reg <= org_x_next;
    end

endmodule
